// File: sv/mwo_pkg.sv
// Shared types, register and waveform codes, and the sine table generator for the
// multi-waveform oscillator.
// No dependencies; every other file of the block except mwo_checker imports this package.
package mwo_pkg;

  // default parameter values
  localparam int PHASE_BITS_DEF     = 16;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 16;

  // fixed field widths
  localparam int TIME_W     = 48;
  localparam int FREQ_W     = 31;
  localparam int FRAC_W     = 40;
  localparam int DUTY_W     = 16;
  localparam int WAVE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_DUTY = 2'd1;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_SILENCE  = 3'd4;
  localparam logic [WAVE_W-1:0] WAVE_PULSE    = 3'd5;

  // register reset values
  localparam logic [WAVE_W-1:0] WAVE_RESET = WAVE_SINE;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 16'h8000;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // live configuration handed to the shaping stages
  typedef struct packed {
    logic [WAVE_W-1:0] wave_sel;
    logic [DUTY_W-1:0] pulse_duty;
  } cfg_t;

  // restoring long division, only evaluated while the table is built
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // one quarter-wave table entry, Taylor series to x^15 in Q30, rounded half up
  function automatic logic [31:0] sine_entry(int k, int addr_bits, int sample_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        den;
    logic [63:0]        maxv;
    logic signed [63:0] sum;
    int                 sh;
    maxv = (64'd1 << (sample_bits - 1)) - 64'd1;
    if (k >= (1 << addr_bits)) begin
      return maxv[31:0];
    end
    x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      den  = 64'((2 * n) * (2 * n + 1));
      term = udiv64((term * x2) >> 30, den);
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    sh  = 31 - sample_bits;
    sum = $signed(($unsigned(sum) + (64'd1 << (sh - 1))) >> sh);
    if (sum > $signed(maxv)) begin
      sum = $signed(maxv);
    end
    return sum[31:0];
  endfunction

endpackage

// File: sv/mwo_phase.sv
// Phase pipeline: split multiply of time by frequency, then the fold that keeps
// the 40 fraction bits and cuts them to the phase width.
// Depends on mwo_pkg.
module mwo_phase #(
  parameter int PHASE_BITS = mwo_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [mwo_pkg::TIME_W-1:0]  elapsed_time,
  input  logic [mwo_pkg::FREQ_W-1:0]  note_frequency,
  output logic                        phase_valid,
  output logic [PHASE_BITS-1:0]       phase
);
  import mwo_pkg::*;

  localparam int LO_T_W  = 24;
  localparam int HI_T_W  = FRAC_W - LO_T_W;
  localparam int LO_P_W  = LO_T_W + FREQ_W;

  logic [LO_P_W-1:0] mul_lo;
  logic [HI_T_W-1:0] mul_hi;
  logic [FRAC_W-1:0] prod_lo_r;
  logic [HI_T_W-1:0] prod_hi_r;
  logic              v1_r;
  logic [FRAC_W-1:0] frac;
  logic [PHASE_BITS-1:0] phase_r;
  logic              v2_r;

  // partial products: low time bits by full frequency, and the part of the
  // upper time bits that still lands inside the fraction
  assign mul_lo = LO_P_W'(elapsed_time[LO_T_W-1:0]) * LO_P_W'(note_frequency);
  assign mul_hi = elapsed_time[LO_T_W +: HI_T_W] * note_frequency[HI_T_W-1:0];

  // stage 1: products
  always_ff @(posedge clk) begin
    prod_lo_r <= mul_lo[FRAC_W-1:0];
    prod_hi_r <= mul_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // stage 2: fold into 40 fraction bits, keep the top phase bits
  assign frac = prod_lo_r + {prod_hi_r, {LO_T_W{1'b0}}};

  always_ff @(posedge clk) begin
    phase_r <= frac[FRAC_W-1 -: PHASE_BITS];
  end

  assign phase_valid = v2_r;
  assign phase       = phase_r;

endmodule

// File: sv/mwo_sine_rom.sv
// Quarter-wave sine ROM with registered read data, table built at elaboration.
// Depends on mwo_pkg for the entry generator.
module mwo_sine_rom #(
  parameter int ADDR_BITS   = mwo_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic [ADDR_BITS:0]     rd_addr,
  output logic [SAMPLE_BITS-2:0] rd_data
);
  import mwo_pkg::*;

  localparam int DEPTH = (1 << ADDR_BITS) + 1;

  typedef logic [SAMPLE_BITS-2:0] entry_t;
  typedef entry_t rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = entry_t'(sine_entry(k, ADDR_BITS, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [SAMPLE_BITS-2:0] rd_data_r;

  // synchronous read
  always_ff @(posedge clk) begin
    rd_data_r <= ROM[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/mwo_shape.sv
// Waveform shaping: sine table lookup and the arithmetic shapes in one stage,
// final select and sine sign in the next.
// Depends on mwo_pkg and mwo_sine_rom.
module mwo_shape #(
  parameter int PHASE_BITS  = mwo_pkg::PHASE_BITS_DEF,
  parameter int ADDR_BITS   = mwo_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mwo_pkg::cfg_t          cfg,
  input  logic                   phase_valid,
  input  logic [PHASE_BITS-1:0]  phase,
  output logic                   sample_valid,
  output logic [SAMPLE_BITS-1:0] sample
);
  import mwo_pkg::*;

  localparam int IDX_W = ADDR_BITS + 2;
  localparam int V_W   = SAMPLE_BITS + 1;

  localparam logic [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [ADDR_BITS:0]     TBL_N = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [V_W-1:0]         TRI_PEAK = {2'b10, {(SAMPLE_BITS-1){1'b0}}};

  logic [IDX_W-1:0]       idx;
  logic [1:0]             quad;
  logic [ADDR_BITS-1:0]   pos;
  logic [ADDR_BITS:0]     rom_addr;
  logic [SAMPLE_BITS-2:0] rom_data;
  logic [V_W-1:0]         tri_v;
  logic [SAMPLE_BITS-1:0] saw_u;
  logic [SAMPLE_BITS-1:0] tri_val;
  logic                   pulse_hi;
  logic [SAMPLE_BITS-1:0] shape_nxt;
  logic [SAMPLE_BITS-1:0] shape_r;
  logic                   sine_sel_r;
  logic                   neg_r;
  logic                   v3_r;
  logic [SAMPLE_BITS-1:0] sine_ext;
  logic [SAMPLE_BITS-1:0] sample_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   v4_r;

  // scale the phase to the table index, the triangle ramp and the saw ramp
  if (PHASE_BITS >= IDX_W) begin : g_idx_dn
    assign idx = IDX_W'(phase >> (PHASE_BITS - IDX_W));
  end else begin : g_idx_up
    assign idx = IDX_W'(phase) << (IDX_W - PHASE_BITS);
  end

  if (V_W >= PHASE_BITS) begin : g_tri_up
    assign tri_v = V_W'(phase) << (V_W - PHASE_BITS);
  end else begin : g_tri_dn
    assign tri_v = V_W'(phase >> (PHASE_BITS - V_W));
  end

  if (SAMPLE_BITS >= PHASE_BITS) begin : g_saw_up
    assign saw_u = SAMPLE_BITS'(phase) << (SAMPLE_BITS - PHASE_BITS);
  end else begin : g_saw_dn
    assign saw_u = SAMPLE_BITS'(phase >> (PHASE_BITS - SAMPLE_BITS));
  end

  // quadrant fold of the table address
  assign quad     = idx[IDX_W-1 -: 2];
  assign pos      = idx[ADDR_BITS-1:0];
  assign rom_addr = quad[0] ? (TBL_N - {1'b0, pos}) : {1'b0, pos};

  mwo_sine_rom #(
    .ADDR_BITS   (ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // triangle: rising half v - 1, falling half 3 - v, peak clipped to max
  always_comb begin
    if (!phase[PHASE_BITS-1]) begin
      tri_val = tri_v[SAMPLE_BITS-1:0] - MIN_S;
    end else if (tri_v == TRI_PEAK) begin
      tri_val = MAX_S;
    end else begin
      tri_val = MIN_S - tri_v[SAMPLE_BITS-1:0];
    end
  end

  // pulse high while phase is below the duty fraction
  assign pulse_hi = {phase, {DUTY_W{1'b0}}} < {cfg.pulse_duty, {PHASE_BITS{1'b0}}};

  // arithmetic shapes
  always_comb begin
    case (cfg.wave_sel)
      WAVE_SINE:     shape_nxt = '0;
      WAVE_TRIANGLE: shape_nxt = tri_val;
      WAVE_SAW:      shape_nxt = {~saw_u[SAMPLE_BITS-1], saw_u[SAMPLE_BITS-2:0]};
      WAVE_SQUARE:   shape_nxt = phase[PHASE_BITS-1] ? MIN_S : MAX_S;
      WAVE_SILENCE:  shape_nxt = '0;
      WAVE_PULSE:    shape_nxt = pulse_hi ? MAX_S : MIN_S;
      default:       shape_nxt = '0;
    endcase
  end

  // stage 3: shapes registered alongside the table read
  always_ff @(posedge clk) begin
    shape_r    <= shape_nxt;
    sine_sel_r <= (cfg.wave_sel == WAVE_SINE);
    neg_r      <= quad[1];
  end

  // stage 4: sign the table value and pick the waveform
  assign sine_ext   = {1'b0, rom_data};
  assign sample_nxt = sine_sel_r ? (neg_r ? (~sine_ext + 1'b1) : sine_ext) : shape_r;

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= phase_valid;
      v4_r <= v3_r;
    end
  end

  assign sample_valid = v4_r;
  assign sample       = sample_r;

endmodule

// File: sv/multi_waveform_oscillator.sv
// Top level of the multi-waveform oscillator: configuration registers and the
// phase and shaping pipelines.
// Depends on mwo_pkg, mwo_phase and mwo_shape.
//
//  port group  direction  handshake          word
//  in_         in         start & !busy      elapsed_time, note_frequency
//  out_        out        out_valid strobe   sample_value
//  cfg_        in         cfg_we             cfg_index, cfg_wdata
//
// One word can be taken every clock cycle while busy is low; its sample passes the
// multiply, fraction fold, sine ROM read and shape, and final select registers.
// rst_n is synchronous; busy is set during reset and cleared by the first clock edge
// that sees rst_n high. The result strobe lasts one cycle and cannot be held off, so
// the pipeline never stalls.
module multi_waveform_oscillator #(
  parameter int PHASE_BITS     = mwo_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = mwo_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = mwo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mwo_pkg::TIME_W-1:0]          in_elapsed_time,
  input  logic [mwo_pkg::FREQ_W-1:0]          in_note_frequency,
  input  logic                                cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_value
);
  import mwo_pkg::*;

  cfg_t                  cfg_r;
  logic                  busy_r;
  logic                  accept;
  logic                  phase_valid;
  logic [PHASE_BITS-1:0] phase;
  logic                  sample_valid;
  logic [SAMPLE_BITS-1:0] sample;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_sel   <= WAVE_RESET;
      cfg_r.pulse_duty <= DUTY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_SEL:   cfg_r.wave_sel   <= cfg_wdata[WAVE_W-1:0];
        REG_PULSE_DUTY: cfg_r.pulse_duty <= cfg_wdata[DUTY_W-1:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // hold off words during reset and until the busy register sees it released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  mwo_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (accept),
    .elapsed_time   (in_elapsed_time),
    .note_frequency (in_note_frequency),
    .phase_valid    (phase_valid),
    .phase          (phase)
  );

  mwo_shape #(
    .PHASE_BITS  (PHASE_BITS),
    .ADDR_BITS   (SINE_ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_shape (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .phase_valid  (phase_valid),
    .phase        (phase),
    .sample_valid (sample_valid),
    .sample       (sample)
  );

  assign out_valid        = sample_valid;
  assign out_sample_value = $signed(sample);

endmodule

// File: sv/mwo_checker.sv
// Port-level checks for the multi-waveform oscillator, bound to the top level.
// Depends only on the top level's ports.
module mwo_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [47:0]                   in_elapsed_time,
  input logic [30:0]                   in_note_frequency,
  input logic                          out_valid,
  input logic signed [SAMPLE_BITS-1:0] out_sample_value
);

  localparam logic signed [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // one result per taken word, once it has passed the pipeline registers, none in between
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4))
    |-> (out_valid == $past(start && !busy, 4)))
    else $error("result strobe does not match a word taken four cycles earlier");

  // zero phase gives only zero, full scale or minus full scale
  a_zero_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(start && !busy && (in_note_frequency == 31'd0 || in_elapsed_time == 48'd0), 4))
    |-> (out_sample_value == '0 || out_sample_value == MAX_S || out_sample_value == MIN_S))
    else $error("zero phase word gave an unexpected sample");

  // ready again in the cycle after reset is released
  a_busy_release: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy held after reset release");

endmodule

bind multi_waveform_oscillator mwo_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mwo_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_elapsed_time   (in_elapsed_time),
  .in_note_frequency (in_note_frequency),
  .out_valid         (out_valid),
  .out_sample_value  (out_sample_value)
);

// File: dv/mwo_sample_checker.sv
`timescale 1ns / 100ps
// Sample checker for the multi-waveform oscillator: tracks register writes, predicts each
// sample from the accepted time and frequency word and compares it with the output strobe.
// Depends on mwo_pkg for widths, register indexes and waveform codes.
module mwo_sample_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic [mwo_pkg::TIME_W-1:0]             in_elapsed_time,
  input  logic [mwo_pkg::FREQ_W-1:0]             in_note_frequency,
  input  logic                                   cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   out_valid,
  input  logic signed [mwo_pkg::SAMPLE_BITS_DEF-1:0] out_sample_value,
  output int                                     mismatch_count,
  output int                                     samples_pending,
  output int                                     samples_seen
);
  import mwo_pkg::*;

  localparam int     PH_W     = PHASE_BITS_DEF;
  localparam int     ADDR_W   = SINE_ADDR_BITS_DEF;
  localparam int     SMP_W    = SAMPLE_BITS_DEF;
  localparam int     PROD_W   = TIME_W + FREQ_W;
  localparam int     ROM_N    = 1 << ADDR_W;
  localparam int     RND_SH   = 31 - SMP_W;
  localparam longint FULL     = longint'(1) << (SMP_W - 1);
  localparam longint PH_HALF  = longint'(1) << (PH_W - 1);

  typedef logic signed [SMP_W-1:0] sample_t;

  // mirrored register state
  logic [WAVE_W-1:0] wave_sel;
  logic [DUTY_W-1:0] duty;

  sample_t quarter_rom [0:ROM_N];
  sample_t expected_samples [$];
  sample_t want;

  // quarter-wave entry: Taylor series of sin in Q30, rounded half up
  function automatic sample_t quarter_sine(int unsigned k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned mono;
    longint          acc;
    if (k >= ROM_N) begin
      return sample_t'(FULL - 1);
    end
    ang    = (HALF_PI_Q30 * 64'(k)) >> ADDR_W;
    ang_sq = (ang * ang) >> 30;
    mono   = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      mono = ((mono * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(mono);
      end else begin
        acc = acc + longint'(mono);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + (longint'(1) << (RND_SH - 1))) >>> RND_SH;
    if (acc > FULL - 1) begin
      acc = FULL - 1;
    end
    return sample_t'(acc);
  endfunction

  // sample for one word under the current register settings
  function automatic sample_t oscillator_sample(logic [TIME_W-1:0] t, logic [FREQ_W-1:0] f);
    logic [PROD_W-1:0]   prod;
    logic [PH_W-1:0]     ph;
    logic [ADDR_W+1:0]   idx;
    logic [1:0]          quad;
    int unsigned         pos;
    longint              lvl;
    longint              s;
    prod = PROD_W'(t) * PROD_W'(f);
    ph   = prod[FRAC_W-1 -: PH_W];
    case (wave_sel)
      WAVE_SINE: begin
        idx  = (ADDR_W + 2)'(ph >> (PH_W - ADDR_W - 2));
        quad = idx[ADDR_W+1:ADDR_W];
        pos  = 32'(idx[ADDR_W-1:0]);
        if (quad[0]) begin
          pos = ROM_N - pos;
        end
        lvl = longint'(quarter_rom[pos]);
        s   = quad[1] ? -lvl : lvl;
      end
      WAVE_TRIANGLE: begin
        lvl = (longint'(ph) << (SMP_W + 1)) >> PH_W;
        s   = (longint'(ph) < PH_HALF) ? lvl - FULL : 3 * FULL - lvl;
        if (s > FULL - 1) begin
          s = FULL - 1;
        end
        if (s < -FULL) begin
          s = -FULL;
        end
      end
      WAVE_SAW: begin
        s = ((longint'(ph) << SMP_W) >> PH_W) - FULL;
      end
      WAVE_SQUARE: begin
        s = (longint'(ph) < PH_HALF) ? FULL - 1 : -FULL;
      end
      WAVE_PULSE: begin
        s = ((longint'(ph) << DUTY_W) < (longint'(duty) << PH_W)) ? FULL - 1 : -FULL;
      end
      default: begin
        s = 0;
      end
    endcase
    return sample_t'(s);
  endfunction

  task automatic report_mismatch(string what, sample_t got, sample_t exp_val);
    $display("mismatch at sample %0d: %s, got %0d expected %0d",
             samples_seen, what, got, exp_val);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    samples_seen   = 0;
    for (int k = 0; k <= ROM_N; k++) begin
      quarter_rom[k] = quarter_sine(k);
    end
  end

  // register mirror, prediction on accept, comparison on strobe
  always @(posedge clk) begin
    if (!rst_n) begin
      wave_sel <= WAVE_RESET;
      duty     <= DUTY_RESET;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVE_SEL:   wave_sel <= cfg_wdata[WAVE_W-1:0];
          REG_PULSE_DUTY: duty     <= cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_samples.push_back(oscillator_sample(in_elapsed_time, in_note_frequency));
      end
      if (out_valid) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample with no word outstanding", out_sample_value, '0);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_value !== want) begin
            report_mismatch("sample_value", out_sample_value, want);
          end
        end
        samples_seen++;
      end
    end
    samples_pending <= expected_samples.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the multi-waveform oscillator: clock, reset, register programming,
// word stimulus with random gaps, watchdog and verdict. Depends on mwo_pkg, the block
// and mwo_sample_checker.
module tb_top;
  import mwo_pkg::*;

  localparam int                    RANDOM_PHASES  = 14;
  localparam int                    WORDS_PER_PHASE = 50;
  localparam int                    DRAIN_CYCLES   = 8;
  localparam int                    WATCHDOG_LIMIT = 400;
  localparam logic [TIME_W-1:0]     TIME_MAX       = '1;
  localparam logic [FREQ_W-1:0]     FREQ_MAX       = 31'd1572864000;
  localparam logic [FREQ_W-1:0]     FREQ_1HZ       = 31'h0001_0000;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_HI  = 2'd3;
  localparam logic [WAVE_W-1:0]     WAVE_SPARE_LO  = 3'd6;
  localparam logic [WAVE_W-1:0]     WAVE_SPARE_HI  = 3'd7;

  logic                           clk;
  logic                           rst_n             = 1'b0;
  logic                           start             = 1'b0;
  logic                           busy;
  logic [TIME_W-1:0]              in_elapsed_time   = '0;
  logic [FREQ_W-1:0]              in_note_frequency = '0;
  logic                           cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index         = '0;
  logic [CFG_DATA_W-1:0]          cfg_wdata         = '0;
  logic                           out_valid;
  logic signed [SAMPLE_BITS_DEF-1:0] out_sample_value;

  int mismatch_count;
  int samples_pending;
  int samples_seen;
  int words_sent    = 0;
  int settings_used = 0;
  int idle_cycles   = 0;

  multi_waveform_oscillator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_elapsed_time   (in_elapsed_time),
    .in_note_frequency (in_note_frequency),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_sample_value  (out_sample_value)
  );

  mwo_sample_checker sample_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_elapsed_time   (in_elapsed_time),
    .in_note_frequency (in_note_frequency),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_sample_value  (out_sample_value),
    .mismatch_count    (mismatch_count),
    .samples_pending   (samples_pending),
    .samples_seen      (samples_seen)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // present one word after a gap and hold it until the block takes it
  task automatic send_word(logic [TIME_W-1:0] t, logic [FREQ_W-1:0] f, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_elapsed_time   <= t;
    in_note_frequency <= f;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // at 1 Hz the phase is bits 23:8 of the time, the rest is free
  task automatic send_phase(logic [15:0] ph);
    send_word({24'($urandom), ph, 8'($urandom)}, FREQ_1HZ, $urandom_range(0, 3));
  endtask

  // let every outstanding sample come out, then allow the pipeline to empty
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (samples_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both registers, optionally poke an unused index, then release the port
  task automatic program_regs(logic [CFG_DATA_W-1:0] sel_word, logic [DUTY_W-1:0] duty_word,
                              bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WAVE_SEL;
    cfg_wdata <= sel_word;
    @(posedge clk);
    cfg_index <= REG_PULSE_DUTY;
    cfg_wdata <= duty_word;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= ($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // watchdog: cycles with no word, no sample and no register write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d samples outstanding", samples_pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       mode;
    int unsigned       kind;
    int unsigned       gap;
    logic [TIME_W-1:0] t;
    logic [FREQ_W-1:0] f;
    logic [WAVE_W-1:0] sel;
    logic [DUTY_W-1:0] duty;

    // reset, then wait for busy to clear
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);

    // reset settings: sine, zero frequency, field extremes, quadrant edges
    send_word('0, '0, 0);
    send_word(TIME_MAX, FREQ_MAX, 0);
    send_word(TIME_MAX, '1, 1);
    send_phase(16'h4000);
    send_phase(16'h8000);
    send_phase(16'hC000);
    send_phase(16'hFFFF);
    drain_pipeline();

    // triangle with junk above the selector, peak saturation at half cycle
    program_regs({13'h1FFF, WAVE_TRIANGLE}, DUTY_RESET, 1'b0);
    send_phase(16'h7FFF);
    send_phase(16'h8000);
    send_phase(16'hFFFF);
    drain_pipeline();

    program_regs({13'h0, WAVE_SAW}, DUTY_RESET, 1'b0);
    send_phase(16'h0000);
    send_phase(16'hFFFF);
    drain_pipeline();

    program_regs({13'h0, WAVE_SQUARE}, DUTY_RESET, 1'b0);
    send_phase(16'h7FFF);
    send_phase(16'h8000);
    drain_pipeline();

    program_regs({13'h0, WAVE_SILENCE}, DUTY_RESET, 1'b0);
    send_word(TIME_MAX, FREQ_MAX, 0);
    drain_pipeline();

    // pulse: zero duty, full duty, duty edge
    program_regs({13'h0, WAVE_PULSE}, 16'h0000, 1'b0);
    send_phase(16'h0000);
    drain_pipeline();
    program_regs({13'h0, WAVE_PULSE}, 16'hFFFF, 1'b0);
    send_phase(16'hFFFE);
    send_phase(16'hFFFF);
    drain_pipeline();
    program_regs({13'h0, WAVE_PULSE}, 16'h1234, 1'b1);
    send_phase(16'h1233);
    send_phase(16'h1234);
    drain_pipeline();

    // unused selector codes read as silence
    program_regs({13'h0, WAVE_SPARE_LO}, DUTY_RESET, 1'b0);
    send_word(TIME_MAX, FREQ_MAX, 0);
    drain_pipeline();
    program_regs({13'h0, WAVE_SPARE_HI}, DUTY_RESET, 1'b1);
    send_word(TIME_MAX, FREQ_MAX, 0);
    drain_pipeline();

    // random phases: each selector once, then random settings
    for (int i = 0; i < RANDOM_PHASES; i++) begin
      sel = (i < 8) ? WAVE_W'(i) : WAVE_W'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
        0:       duty = 16'h0000;
        1:       duty = 16'hFFFF;
        2:       duty = 16'h0001;
        3:       duty = DUTY_RESET;
        default: duty = 16'($urandom);
      endcase
      program_regs({13'($urandom), sel}, duty, $urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        t    = {16'($urandom), 32'($urandom)};
        f    = FREQ_W'($urandom_range(0, FREQ_MAX));
        case (kind)
          0: f = '0;
          1: f = FREQ_W'($urandom);
          2: f = FREQ_1HZ;
          3: t = TIME_W'($urandom_range(0, 255));
          4: t = TIME_MAX;
          default: ;
        endcase
        // back-to-back, fully random gaps, or occasional gaps
        case (mode)
          0:       gap = 0;
          1:       gap = $urandom_range(0, 12);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        endcase
        send_word(t, f, gap);
      end
      drain_pipeline();
    end

    $display("covered %0d words over %0d register settings: all six waveforms,",
             words_sent, settings_used);
    $display("both spare selector codes and pulse duty extremes; %0d samples compared",
             samples_seen);
    if (samples_pending != 0) begin
      $display("%0d expected samples never appeared", samples_pending);
    end
    if (mismatch_count == 0 && samples_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
